// File: rtl/core/gddt_pkg.sv
// ----------------------------------------------------------------------------
// gddt_pkg: shared types and constants
// Mode codes, ASCII codes and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package gddt_pkg;

    localparam int DELAY_W = 20;

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_EDGE = 2'd1,
        MODE_RX   = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 20'd80;

    // parse windows: first argument byte and its length
    localparam int PARSE_FIRST = 3;
    localparam int PARSE_LEN   = 6;
    localparam int DIGITS_MAX  = 8;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_EDGE,
        OP_STORE,
        OP_CLEAR,
        OP_PARSE_STEP,
        OP_CONV_STEP,
        OP_WRITE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   latch_in;
    } dp_cmd_t;

    typedef struct packed {
        logic       cmd_r;
        logic       cmd_w;
        logic       cmd_p;
        logic       cmd_s;
        logic       sel_ok;
        logic       triggers;
        logic       parse_done;
        logic       conv_done;
    } dp_stat_t;

endpackage

// File: rtl/core/gddt_stream_if.sv
// ----------------------------------------------------------------------------
// gddt_stream_if: valid/ready channel
// Carries one payload per transfer.
// ----------------------------------------------------------------------------
interface gddt_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/gddt_datapath.sv
// ----------------------------------------------------------------------------
// gddt_datapath: state registers, command buffer, parse and format units
// Executes one operation per cycle on command from the controller.
// ----------------------------------------------------------------------------
module gddt_datapath #(
    parameter int CMD_DEPTH   = 10,
    parameter int REPLY_BYTES = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gddt_pkg::dp_cmd_t    cmd,
    input  logic [8:0]           in_data,
    input  logic [$clog2(REPLY_BYTES)-1:0] reply_idx,
    output gddt_pkg::dp_stat_t   stat,
    output logic [7:0]           reply_byte,
    output logic [1:0]           levels
);
    localparam int FW = $clog2(CMD_DEPTH + 1);
    localparam int AW = $clog2(CMD_DEPTH);
    localparam int DW = gddt_pkg::DELAY_W;

    logic [7:0]    buf_reg [CMD_DEPTH];
    logic [FW-1:0] fill_reg;
    logic [DW-1:0] dz_reg, d1_reg, cz_reg, c1_reg;
    logic          run_reg, az_reg, a1_reg;
    logic [1:0]    lev_reg;
    logic          gate_reg;
    logic [7:0]    rx_reg;

    // parse state: 0 leading whitespace, 2 after a sign or digit (1 is never used)
    logic [1:0]    pphase_reg;
    logic [2:0]    pidx_reg;
    logic          neg_reg, pdone_reg;
    logic [DW-1:0] acc_reg;

    // conversion: digits collected least significant first
    logic [DW-1:0] cval_reg;
    logic [3:0]    cnt_reg;
    logic          cdone_reg;
    logic [3:0]    dig_reg [gddt_pkg::DIGITS_MAX];

    logic [AW-1:0] paddr;
    logic [7:0]    pc;
    logic          pws, pdig;
    logic [DW-1:0] q10;
    logic [3:0]    r10;
    logic [DW+4:0] qmul;
    logic [DW-1:0] acc_mul;
    logic [7:0]    sel_byte;

    assign paddr = AW'(gddt_pkg::PARSE_FIRST) + AW'(pidx_reg);
    assign pc    = buf_reg[paddr];
    assign pws  = (pc == gddt_pkg::CH_SPACE) || (pc >= 8'd9 && pc <= 8'd13);
    assign pdig = (pc >= gddt_pkg::CH_ZERO) && (pc <= 8'h39);
    // selector as it stands after this store
    assign sel_byte = (fill_reg == FW'(1)) ? rx_reg : buf_reg[1];
    // divide by ten via reciprocal, then correct once
    always_comb
    begin
        logic [2*DW+3:0] prod;
        logic [DW-1:0]   q;
        logic [DW+3:0]   rem;
        prod = (2*DW+4)'(cval_reg) * (2*DW+4)'(24'd838861);
        q    = DW'(prod >> 23);
        rem  = (DW+4)'(cval_reg) - (DW+4)'(q) * (DW+4)'(10);
        if (rem >= (DW+4)'(10))
        begin
            q   = q + DW'(1);
            rem = rem - (DW+4)'(10);
        end
        q10 = q;
        r10 = rem[3:0];
    end
    assign qmul    = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0} + (DW+5)'(pc - 8'h30);
    assign acc_mul = qmul[DW-1:0];

    assign stat.cmd_r      = buf_reg[0] == gddt_pkg::CH_R;
    assign stat.cmd_w      = buf_reg[0] == gddt_pkg::CH_W;
    assign stat.cmd_p      = buf_reg[0] == gddt_pkg::CH_P;
    assign stat.cmd_s      = buf_reg[0] == gddt_pkg::CH_S;
    assign stat.sel_ok     = buf_reg[1] == gddt_pkg::CH_ZERO || buf_reg[1] == gddt_pkg::CH_ONE;
    assign stat.triggers   = gate_reg && run_reg;
    assign stat.parse_done = pdone_reg;
    assign stat.conv_done  = cdone_reg;
    assign levels          = lev_reg;

    always_comb
    begin
        reply_byte = gddt_pkg::CH_SPACE;
        if (stat.sel_ok && 4'(reply_idx) < cnt_reg)
            reply_byte = gddt_pkg::CH_ZERO
                + 8'(dig_reg[3'(cnt_reg - 4'd1 - 4'(reply_idx))]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            gate_reg <= in_data[8];
            rx_reg   <= in_data[7:0];
        end
        if (cmd.op == gddt_pkg::OP_CONV_STEP && !cdone_reg)
            dig_reg[cnt_reg[2:0]] <= r10;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CMD_DEPTH; i++)
                buf_reg[i] <= 8'd0;
            fill_reg   <= '0;
            dz_reg     <= gddt_pkg::DELAY_RESET;
            d1_reg     <= gddt_pkg::DELAY_RESET;
            cz_reg     <= '0;
            c1_reg     <= '0;
            run_reg    <= 1'b1;
            az_reg     <= 1'b0;
            a1_reg     <= 1'b0;
            lev_reg    <= 2'b00;
            pphase_reg <= 2'd0;
            pidx_reg   <= 3'd0;
            neg_reg    <= 1'b0;
            pdone_reg  <= 1'b0;
            acc_reg    <= '0;
            cval_reg   <= '0;
            cnt_reg    <= 4'd0;
            cdone_reg  <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                gddt_pkg::OP_TICK:
                begin
                    if (az_reg)
                    begin
                        if (cz_reg <= DW'(1))
                        begin
                            az_reg <= 1'b0; cz_reg <= '0; lev_reg[0] <= 1'b1;
                        end
                        else
                            cz_reg <= cz_reg - DW'(1);
                    end
                    if (a1_reg)
                    begin
                        if (c1_reg <= DW'(1))
                        begin
                            a1_reg <= 1'b0; c1_reg <= '0; lev_reg[1] <= 1'b1;
                        end
                        else
                            c1_reg <= c1_reg - DW'(1);
                    end
                end
                gddt_pkg::OP_EDGE:
                begin
                    lev_reg <= 2'b00;
                    if (gate_reg && run_reg)
                    begin
                        cz_reg <= dz_reg; c1_reg <= d1_reg;
                        az_reg <= 1'b1;   a1_reg <= 1'b1;
                    end
                end
                gddt_pkg::OP_STORE:
                begin
                    if (32'(fill_reg) < CMD_DEPTH)
                    begin
                        buf_reg[fill_reg[$clog2(CMD_DEPTH)-1:0]] <= rx_reg;
                        fill_reg <= fill_reg + FW'(1);
                    end
                    // arm parse and convert for the next command
                    pphase_reg <= 2'd0; pidx_reg <= 3'd0; neg_reg <= 1'b0;
                    pdone_reg  <= 1'b0; acc_reg <= '0;
                    cval_reg   <= (sel_byte == gddt_pkg::CH_ONE) ? d1_reg : dz_reg;
                    cnt_reg    <= 4'd0; cdone_reg <= 1'b0;
                end
                gddt_pkg::OP_PARSE_STEP:
                begin
                    if (!pdone_reg)
                    begin
                        if (32'(pidx_reg) >= gddt_pkg::PARSE_LEN)
                            pdone_reg <= 1'b1;
                        else if (pphase_reg == 2'd0 && pws)
                            pidx_reg <= pidx_reg + 3'd1;
                        else if (pphase_reg != 2'd2 &&
                                 (pc == gddt_pkg::CH_PLUS || pc == gddt_pkg::CH_MINUS))
                        begin
                            neg_reg    <= pc == gddt_pkg::CH_MINUS;
                            pidx_reg   <= pidx_reg + 3'd1;
                            pphase_reg <= 2'd2;
                        end
                        else if (pdig)
                        begin
                            acc_reg    <= acc_mul;
                            pidx_reg   <= pidx_reg + 3'd1;
                            pphase_reg <= 2'd2;
                        end
                        else
                            pdone_reg <= 1'b1;
                    end
                end
                gddt_pkg::OP_CONV_STEP:
                begin
                    if (!cdone_reg)
                    begin
                        cval_reg <= q10;
                        cnt_reg  <= cnt_reg + 4'd1;
                        if (q10 == '0 || cnt_reg == 4'(gddt_pkg::DIGITS_MAX - 1))
                            cdone_reg <= 1'b1;
                    end
                end
                gddt_pkg::OP_WRITE:
                begin
                    if (buf_reg[1] == gddt_pkg::CH_ZERO)
                        dz_reg <= neg_reg ? '0 : acc_reg;
                    else if (buf_reg[1] == gddt_pkg::CH_ONE)
                        d1_reg <= neg_reg ? '0 : acc_reg;
                end
                gddt_pkg::OP_CLEAR:
                begin
                    if (stat.cmd_p)
                        run_reg <= 1'b0;
                    else if (stat.cmd_s)
                        run_reg <= 1'b1;
                    for (int i = 0; i < CMD_DEPTH; i++)
                        buf_reg[i] <= 8'd0;
                    fill_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// File: rtl/core/gddt_ctrl.sv
// ----------------------------------------------------------------------------
// gddt_ctrl: sequencer and output register
// Accepts one item, steps the datapath, then emits its results.
// ----------------------------------------------------------------------------
module gddt_ctrl #(
    parameter int REPLY_BYTES = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [10:0]        in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [21:0]        out_data,
    output gddt_pkg::dp_cmd_t  cmd,
    output logic [$clog2(REPLY_BYTES)-1:0] reply_idx,
    input  gddt_pkg::dp_stat_t stat,
    input  logic [7:0]         reply_byte,
    input  logic [1:0]         levels
);
    localparam int RW = $clog2(REPLY_BYTES);

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_PARSE, S_CONV, S_CMD, S_EMIT
    } state_t;

    state_t           state_reg;
    logic [1:0]       mode_reg;
    logic [7:0]       rx_reg;
    logic             tx_reg;     // results carry bytes
    logic             event_reg;  // event reply rather than read reply
    logic [RW-1:0]    idx_reg;

    logic [RW-1:0]    idx_next;
    logic             emit_last;

    assign in_ready  = state_reg == S_IDLE;
    assign reply_idx = idx_reg;
    assign emit_last = !tx_reg || 32'(idx_reg) == REPLY_BYTES - 1;
    assign idx_next  = idx_reg + RW'(1);

    always_comb
    begin
        logic [7:0] b;
        b = event_reg ? ((idx_reg == '0) ? gddt_pkg::CH_E : gddt_pkg::CH_SPACE) : reply_byte;
        out_valid = state_reg == S_EMIT;
        out_data  = {{8{levels[1]}}, {4{levels[0]}}, tx_reg, tx_reg ? b : 8'd0, emit_last};
    end

    always_comb
    begin
        cmd.latch_in = in_valid && in_ready;
        cmd.op       = gddt_pkg::OP_NONE;
        unique case (state_reg)
            S_EXEC:
            begin
                priority case (mode_reg)
                    gddt_pkg::MODE_TICK: cmd.op = gddt_pkg::OP_TICK;
                    gddt_pkg::MODE_EDGE: cmd.op = gddt_pkg::OP_EDGE;
                    gddt_pkg::MODE_RX:
                        if (rx_reg != gddt_pkg::CH_CR) cmd.op = gddt_pkg::OP_STORE;
                    default: cmd.op = gddt_pkg::OP_NONE;
                endcase
            end
            S_PARSE: cmd.op = stat.parse_done ? gddt_pkg::OP_WRITE
                                              : gddt_pkg::OP_PARSE_STEP;
            S_CONV:  cmd.op = gddt_pkg::OP_CONV_STEP;
            S_CMD:   cmd.op = gddt_pkg::OP_CLEAR;
            S_EMIT:
                if (emit_last && out_ready && !event_reg && tx_reg)
                    cmd.op = gddt_pkg::OP_CLEAR;
            default: cmd.op = gddt_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= 2'd0;
            rx_reg    <= 8'd0;
            tx_reg    <= 1'b0;
            event_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (in_valid)
                    begin
                        mode_reg  <= in_data[10:9];
                        rx_reg    <= in_data[7:0];
                        tx_reg    <= 1'b0;
                        event_reg <= 1'b0;
                        idx_reg   <= '0;
                        state_reg <= S_EXEC;
                    end
                S_EXEC:
                begin
                    state_reg <= S_EMIT;
                    if (mode_reg == gddt_pkg::MODE_EDGE && stat.triggers)
                    begin
                        tx_reg <= 1'b1; event_reg <= 1'b1;
                    end
                    else if (mode_reg == gddt_pkg::MODE_RX && rx_reg == gddt_pkg::CH_CR)
                    begin
                        if (stat.cmd_r)
                            state_reg <= S_CONV;
                        else if (stat.cmd_w && stat.sel_ok)
                            state_reg <= S_PARSE;
                        else
                            state_reg <= S_CMD;
                    end
                end
                S_PARSE:
                    if (stat.parse_done) state_reg <= S_CMD;
                S_CONV:
                    if (stat.conv_done)
                    begin
                        tx_reg    <= 1'b1;
                        state_reg <= S_EMIT;
                    end
                S_CMD:
                    state_reg <= S_EMIT;
                S_EMIT:
                    if (out_ready)
                    begin
                        if (emit_last) state_reg <= S_IDLE;
                        else           idx_reg   <= idx_next;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/core/gated_dual_delay_trigger_unit.sv
// ----------------------------------------------------------------------------
// gated_dual_delay_trigger_unit: two-channel delayed trigger with serial port
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// One item is worked at a time. A tick, an edge or a stored byte passes the
// execute state to its single result; an event reply then streams REPLY_BYTES
// results. A write command walks up to six argument bytes one per cycle, a
// read command converts the delay one decimal digit per cycle (up to 8
// digits) before its reply. Results go out one per cycle while the sink is
// ready; the input is taken again once the last one transfers.
module gated_dual_delay_trigger_unit #(
    parameter int CMD_DEPTH   = 10,
    parameter int REPLY_BYTES = 5
) (
    input logic          clk,
    input logic          rst_n,
    gddt_stream_if.sink   in_ch,
    gddt_stream_if.source out_ch
);
    gddt_pkg::dp_cmd_t  cmd;
    gddt_pkg::dp_stat_t stat;
    logic [7:0]         reply_byte;
    logic [1:0]         levels;
    logic [$clog2(REPLY_BYTES)-1:0] reply_idx;

    gddt_ctrl #(.REPLY_BYTES(REPLY_BYTES)) u_ctrl (
        .clk, .rst_n,
        .in_valid (in_ch.valid), .in_ready (in_ch.ready), .in_data (in_ch.data),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
        .cmd, .reply_idx, .stat, .reply_byte, .levels
    );

    gddt_datapath #(.CMD_DEPTH(CMD_DEPTH), .REPLY_BYTES(REPLY_BYTES)) u_dp (
        .clk, .rst_n, .cmd, .in_data(in_ch.data[8:0]), .reply_idx,
        .stat, .reply_byte, .levels
    );
endmodule

// File: rtl/core/gddt_checker.sv
// ----------------------------------------------------------------------------
// gddt_checker: port-level checks
// Watches the channel handshakes of the top level.
// ----------------------------------------------------------------------------
module gddt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [21:0] out_data
);
    // no new input while results are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken during output");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output not held");
    a_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("ready after transfer");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data[0] |=> in_ready)
        else $error("not idle after last");
endmodule

bind gated_dual_delay_trigger_unit gddt_checker u_chk (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
